// ===== hw/rtl/dpms_pkg.sv =====
// ----------------------------------------------------------------------------
// dpms_pkg
// shared codes, register indexes and beat types of the depth profile sequencer
// ----------------------------------------------------------------------------
package dpms_pkg;

   // mission phases
   localparam logic [2:0] PH_IDLE         = 3'd0;
   localparam logic [2:0] PH_DESCEND      = 3'd1;
   localparam logic [2:0] PH_HOLD_DEEP    = 3'd2;
   localparam logic [2:0] PH_ASCEND       = 3'd3;
   localparam logic [2:0] PH_HOLD_SHALLOW = 3'd4;
   localparam logic [2:0] PH_SURFACE      = 3'd5;
   localparam logic [2:0] PH_DONE         = 3'd6;

   // request actions
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_ABORT = 2'd2;

   // safety events
   localparam logic [1:0] SAFE_NONE      = 2'd0;
   localparam logic [1:0] SAFE_OVERDEPTH = 2'd1;
   localparam logic [1:0] SAFE_TIMEOUT   = 2'd2;

   // register indexes
   localparam logic [2:0] REG_DEEP_MIN     = 3'd0;
   localparam logic [2:0] REG_DEEP_MAX     = 3'd1;
   localparam logic [2:0] REG_SHALLOW_MIN  = 3'd2;
   localparam logic [2:0] REG_SHALLOW_MAX  = 3'd3;
   localparam logic [2:0] REG_SURFACE      = 3'd4;
   localparam logic [2:0] REG_MAX_DEPTH    = 3'd5;
   localparam logic [2:0] REG_HOLD_TIME    = 3'd6;
   localparam logic [2:0] REG_DESC_TIMEOUT = 3'd7;

   typedef struct packed {
      logic [14:0] deep_min_mm;
      logic [14:0] deep_max_mm;
      logic [14:0] shallow_min_mm;
      logic [14:0] shallow_max_mm;
      logic [14:0] surface_mm;
      logic [14:0] max_depth_mm;
      logic [23:0] hold_time_ms;
      logic [23:0] descend_timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  phase;
      logic [1:0]  profiles_done;
      logic [31:0] phase_start_time;
      logic [31:0] hold_start_time;
      logic        hold_timing;
      logic        pump_running;
      logic [7:0]  pump_duty;
   } state_type;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [15:0] depth_mm;
      logic [31:0]        time_ms;
   } req_beat_type;

   typedef struct packed {
      logic [2:0] mission_state;
      logic [1:0] profile_number;
      logic       pump_on;
      logic [7:0] pump_speed;
      logic       in_band;
      logic [1:0] safety_event;
      logic       mission_complete;
   } rsp_beat_type;

endpackage

// ===== hw/rtl/dpms_if.sv =====
// ----------------------------------------------------------------------------
// dpms channel interfaces
// request, response and register write channels with valid and ready
// ----------------------------------------------------------------------------
interface dpms_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [15:0] depth_mm;
   logic [31:0]        time_ms;

   modport source (output valid, action, depth_mm, time_ms, input ready);
   modport sink (input valid, action, depth_mm, time_ms, output ready);
endinterface

interface dpms_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] mission_state;
   logic [1:0] profile_number;
   logic       pump_on;
   logic [7:0] pump_speed;
   logic       in_band;
   logic [1:0] safety_event;
   logic       mission_complete;

   modport source (output valid, mission_state, profile_number, pump_on, pump_speed,
                   in_band, safety_event, mission_complete, input ready);
   modport sink (input valid, mission_state, profile_number, pump_on, pump_speed,
                 in_band, safety_event, mission_complete, output ready);
endinterface

interface dpms_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [23:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/dpms_csr.sv =====
// ----------------------------------------------------------------------------
// dpms_csr
// mission configuration registers with their reset values
// ----------------------------------------------------------------------------
module dpms_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   input  logic [2:0]       wr_index,
   input  logic [23:0]      wr_data,
   output dpms_pkg::cfg_type cfg
);
   import dpms_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deep_min_mm        <= 15'd2270;
         cfg_ff.deep_max_mm        <= 15'd2830;
         cfg_ff.shallow_min_mm     <= 15'd375;
         cfg_ff.shallow_max_mm     <= 15'd1035;
         cfg_ff.surface_mm         <= 15'd100;
         cfg_ff.max_depth_mm       <= 15'd3200;
         cfg_ff.hold_time_ms       <= 24'd30000;
         cfg_ff.descend_timeout_ms <= 24'd90000;
      end else if (wr_valid) begin
         unique case (wr_index)
            REG_DEEP_MIN:     cfg_ff.deep_min_mm        <= wr_data[14:0];
            REG_DEEP_MAX:     cfg_ff.deep_max_mm        <= wr_data[14:0];
            REG_SHALLOW_MIN:  cfg_ff.shallow_min_mm     <= wr_data[14:0];
            REG_SHALLOW_MAX:  cfg_ff.shallow_max_mm     <= wr_data[14:0];
            REG_SURFACE:      cfg_ff.surface_mm         <= wr_data[14:0];
            REG_MAX_DEPTH:    cfg_ff.max_depth_mm       <= wr_data[14:0];
            REG_HOLD_TIME:    cfg_ff.hold_time_ms       <= wr_data;
            REG_DESC_TIMEOUT: cfg_ff.descend_timeout_ms <= wr_data;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/dpms_step.sv =====
// ----------------------------------------------------------------------------
// dpms_step
// next mission state and response for one request beat
// ----------------------------------------------------------------------------
module dpms_step #(
   parameter int PROFILES   = 3,
   parameter int FULL_SPEED = 255,
   parameter int HOLD_SPEED = 90
) (
   input  dpms_pkg::state_type    cur,
   input  dpms_pkg::cfg_type      cfg,
   input  dpms_pkg::req_beat_type req,
   output dpms_pkg::state_type    nxt,
   output dpms_pkg::rsp_beat_type rsp
);
   import dpms_pkg::*;

   logic signed [17:0] depth_x;
   logic signed [17:0] depth2_x;
   logic signed [17:0] lo_x;
   logic signed [17:0] hi_x;
   logic signed [17:0] mid2_x;
   logic [14:0]        band_lo;
   logic [14:0]        band_hi;
   logic [31:0]        descend_elapsed;
   logic [31:0]        hold_elapsed;
   logic               over_depth;
   logic               timed_out;
   logic               band_hit;
   logic               hold_finished;
   logic [1:0]         profiles_inc;
   logic               inb;
   logic [1:0]         safety;
   logic               done_pulse;

   // band of whichever hold phase is current
   always_comb begin
      if (cur.phase == PH_HOLD_DEEP) begin
         band_lo = cfg.deep_min_mm;
         band_hi = cfg.deep_max_mm;
      end else begin
         band_lo = cfg.shallow_min_mm;
         band_hi = cfg.shallow_max_mm;
      end
   end

   assign depth_x  = 18'(req.depth_mm);
   assign depth2_x = {depth_x[16:0], 1'b0};
   assign lo_x     = $signed({3'b000, band_lo});
   assign hi_x     = $signed({3'b000, band_hi});
   assign mid2_x   = lo_x + hi_x;
   assign band_hit = (depth_x >= lo_x) && (depth_x <= hi_x);

   assign over_depth      = depth_x > $signed({3'b000, cfg.max_depth_mm});
   assign descend_elapsed = req.time_ms - cur.phase_start_time;
   assign timed_out       = descend_elapsed > {8'd0, cfg.descend_timeout_ms};

   // timer restarts on the first in-band tick, so elapsed is then zero
   assign hold_elapsed  = cur.hold_timing ? (req.time_ms - cur.hold_start_time) : 32'd0;
   assign hold_finished = hold_elapsed >= {8'd0, cfg.hold_time_ms};
   assign profiles_inc  = cur.profiles_done + 2'd1;

   always_comb begin
      nxt        = cur;
      inb        = 1'b0;
      safety     = SAFE_NONE;
      done_pulse = 1'b0;

      unique case (req.action)
         ACT_START: begin
            nxt.profiles_done    = 2'd0;
            nxt.phase            = PH_DESCEND;
            nxt.phase_start_time = req.time_ms;
            nxt.hold_timing      = 1'b0;
         end
         ACT_ABORT: begin
            nxt.pump_running     = 1'b0;
            nxt.pump_duty        = 8'd0;
            nxt.phase            = PH_IDLE;
            nxt.phase_start_time = req.time_ms;
            nxt.hold_timing      = 1'b0;
         end
         ACT_TICK: begin
            priority if (cur.phase == PH_IDLE || cur.phase >= PH_DONE) begin
               nxt.pump_running = 1'b0;
               nxt.pump_duty    = 8'd0;
            end else if (over_depth || (cur.phase == PH_DESCEND && timed_out)) begin
               nxt.pump_running     = 1'b0;
               nxt.pump_duty        = 8'd0;
               nxt.phase            = PH_SURFACE;
               nxt.phase_start_time = req.time_ms;
               nxt.hold_timing      = 1'b0;
               safety               = over_depth ? SAFE_OVERDEPTH : SAFE_TIMEOUT;
            end else begin
               unique case (cur.phase)
                  PH_DESCEND: begin
                     nxt.pump_running = 1'b1;
                     nxt.pump_duty    = 8'(FULL_SPEED);
                     if (depth_x >= $signed({3'b000, cfg.deep_min_mm})) begin
                        nxt.phase            = PH_HOLD_DEEP;
                        nxt.phase_start_time = req.time_ms;
                        nxt.hold_timing      = 1'b0;
                     end
                  end
                  PH_HOLD_DEEP, PH_HOLD_SHALLOW: begin
                     // bang-bang about the band midpoint
                     if (depth2_x < mid2_x) begin
                        nxt.pump_running = 1'b1;
                        nxt.pump_duty    = 8'(HOLD_SPEED);
                     end else begin
                        nxt.pump_running = 1'b0;
                        nxt.pump_duty    = 8'd0;
                     end
                     inb = band_hit;
                     if (band_hit) begin
                        if (!cur.hold_timing) begin
                           nxt.hold_timing     = 1'b1;
                           nxt.hold_start_time = req.time_ms;
                        end
                        if (hold_finished) begin
                           nxt.phase            = (cur.phase == PH_HOLD_DEEP) ?
                                                  PH_ASCEND : PH_SURFACE;
                           nxt.phase_start_time = req.time_ms;
                           nxt.hold_timing      = 1'b0;
                        end
                     end else begin
                        nxt.hold_timing = 1'b0;
                     end
                  end
                  PH_ASCEND: begin
                     nxt.pump_running = 1'b0;
                     nxt.pump_duty    = 8'd0;
                     if (depth_x <= $signed({3'b000, cfg.shallow_max_mm})) begin
                        nxt.phase            = PH_HOLD_SHALLOW;
                        nxt.phase_start_time = req.time_ms;
                        nxt.hold_timing      = 1'b0;
                     end
                  end
                  default: begin
                     // surface
                     nxt.pump_running = 1'b0;
                     nxt.pump_duty    = 8'd0;
                     if (depth_x <= $signed({3'b000, cfg.surface_mm})) begin
                        nxt.profiles_done    = profiles_inc;
                        nxt.phase_start_time = req.time_ms;
                        nxt.hold_timing      = 1'b0;
                        if (32'(profiles_inc) >= PROFILES) begin
                           nxt.phase  = PH_DONE;
                           done_pulse = 1'b1;
                        end else begin
                           nxt.phase = PH_DESCEND;
                        end
                     end
                  end
               endcase
            end
         end
         default: ;
      endcase
   end

   assign rsp.mission_state    = nxt.phase;
   assign rsp.profile_number   = nxt.profiles_done;
   assign rsp.pump_on          = nxt.pump_running;
   assign rsp.pump_speed       = nxt.pump_duty;
   assign rsp.in_band          = inb;
   assign rsp.safety_event     = safety;
   assign rsp.mission_complete = done_pulse;

endmodule

// ===== hw/rtl/depth_profile_mission_sequencer.sv =====
// ----------------------------------------------------------------------------
// depth_profile_mission_sequencer
// profiling float mission sequencer: descend, hold deep, ascend, hold shallow,
// surface, repeated for a set number of profiles
// ----------------------------------------------------------------------------
// usage
//   req_chan carries one beat per tick or command: action, depth_mm, time_ms
//   rsp_chan returns exactly one beat per request beat, in order, showing the
//   mission state, pump drive and event flags after that request
//   csr_chan writes one configuration register per beat (index, data); it is
//   always ready and must only be used while no request is in flight
// pipeline and throughput
//   a request accepted into the input register is processed through the step
//   logic into the response register once that register is free or draining,
//   and is shown on rsp_chan from then on. One beat per cycle sustained while
//   rsp_chan.ready is high; the step logic is a handful of compares and 32-bit
//   time subtractions between the request and response registers
// reset
//   synchronous, active high: mission idle, pump off, profile count zero,
//   configuration registers back to their defaults, both stages empty
// stalls
//   while rsp_chan.ready is low the response beat holds; one more request is
//   taken into the input register, after which req_chan.ready drops
// ----------------------------------------------------------------------------
module depth_profile_mission_sequencer #(
   parameter int PROFILES   = 3,
   parameter int FULL_SPEED = 255,
   parameter int HOLD_SPEED = 90
) (
   input logic        clock,
   input logic        reset,
   dpms_req_if.sink   req_chan,
   dpms_rsp_if.source rsp_chan,
   dpms_csr_if.sink   csr_chan
);
   import dpms_pkg::*;

   cfg_type      cfg;

   // input stage
   logic         in_valid_ff;
   req_beat_type in_beat_ff;

   // response stage
   logic         out_valid_ff;
   rsp_beat_type out_beat_ff;

   // mission state
   state_type    state_ff;
   state_type    state_in;
   rsp_beat_type rsp_in;

   logic         advance;
   logic         req_take;

   // the input beat moves on whenever the response register is free or draining
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   dpms_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_chan.valid),
      .wr_index (csr_chan.index),
      .wr_data  (csr_chan.data),
      .cfg      (cfg)
   );

   dpms_step #(
      .PROFILES   (PROFILES),
      .FULL_SPEED (FULL_SPEED),
      .HOLD_SPEED (HOLD_SPEED)
   ) u_step (
      .cur (state_ff),
      .cfg (cfg),
      .req (in_beat_ff),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_beat_ff.action   <= req_chan.action;
         in_beat_ff.depth_mm <= req_chan.depth_mm;
         in_beat_ff.time_ms  <= req_chan.time_ms;
      end
   end

   // mission state only moves when a beat is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_beat_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.mission_state    = out_beat_ff.mission_state;
   assign rsp_chan.profile_number   = out_beat_ff.profile_number;
   assign rsp_chan.pump_on          = out_beat_ff.pump_on;
   assign rsp_chan.pump_speed       = out_beat_ff.pump_speed;
   assign rsp_chan.in_band          = out_beat_ff.in_band;
   assign rsp_chan.safety_event     = out_beat_ff.safety_event;
   assign rsp_chan.mission_complete = out_beat_ff.mission_complete;

endmodule

// ===== hw/rtl/dpms_checker.sv =====
// ----------------------------------------------------------------------------
// dpms_checker
// port-level checks on the sequencer's response channel
// ----------------------------------------------------------------------------
module dpms_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] mission_state,
   input logic       pump_on,
   input logic [7:0] pump_speed,
   input logic [1:0] safety_event,
   input logic       mission_complete
);
   import dpms_pkg::*;

   // stalled response beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // nothing offered straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // pump duty only with pump running
   a_pump_off_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !pump_on |-> pump_speed == 8'd0)
      else $error("pump duty non-zero with pump off");

   // a safety event forces surfacing with the pump off
   a_safety_surface: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && safety_event != SAFE_NONE |-> mission_state == PH_SURFACE && !pump_on)
      else $error("safety event without surfacing");

   // completion pulse only lands in the done phase with the pump off
   a_done_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && mission_complete |-> mission_state == PH_DONE && !pump_on)
      else $error("mission complete outside done phase");

endmodule

bind depth_profile_mission_sequencer dpms_checker u_dpms_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .mission_state    (rsp_chan.mission_state),
   .pump_on          (rsp_chan.pump_on),
   .pump_speed       (rsp_chan.pump_speed),
   .safety_event     (rsp_chan.safety_event),
   .mission_complete (rsp_chan.mission_complete)
);
